// ----- src/ppr_pkg.sv -----
// Shared types, constants and helper functions for the planar pose re-origin block.
`timescale 1ns / 1ps
package ppr_pkg;

   localparam int QUEUE_DEPTH = 2;

   localparam logic signed [39:0] ONE_Q28      = 40'sd268435456;
   localparam logic signed [39:0] GAIN_INV_Q28 = 40'sd163008219;
   localparam logic signed [33:0] QUARTER_TURN = 34'sd1073741824;
   localparam logic signed [33:0] HALF_TURN    = 34'sd2147483648;
   localparam logic signed [67:0] ROUND_Q28    = 68'sd134217728;

   typedef struct packed {
      logic signed [31:0] pos_x;
      logic signed [31:0] pos_y;
      logic signed [15:0] quat_x;
      logic signed [15:0] quat_y;
      logic signed [15:0] quat_z;
      logic signed [15:0] quat_w;
   } ppr_entry_type;

   typedef enum logic [3:0] {
      BK_IDLE,
      BK_QMUL,
      BK_AINIT,
      BK_ATAN,
      BK_S1INIT,
      BK_SC1,
      BK_S2INIT,
      BK_SC2,
      BK_ROT,
      BK_RFIN
   } bk_state_type;

   // atan(2^-i) in 2^-32 turn units
   function automatic logic [31:0] atan_lut(input logic [4:0] idx);
      logic [31:0] r;
      case (idx)
         5'd0:  r = 32'h20000000;
         5'd1:  r = 32'h12E4051E;
         5'd2:  r = 32'h09FB385B;
         5'd3:  r = 32'h051111D4;
         5'd4:  r = 32'h028B0D43;
         5'd5:  r = 32'h0145D7E1;
         5'd6:  r = 32'h00A2F61E;
         5'd7:  r = 32'h00517C55;
         5'd8:  r = 32'h0028BE53;
         5'd9:  r = 32'h00145F2F;
         5'd10: r = 32'h000A2F98;
         5'd11: r = 32'h000517CC;
         5'd12: r = 32'h00028BE6;
         5'd13: r = 32'h000145F3;
         5'd14: r = 32'h0000A2FA;
         5'd15: r = 32'h0000517D;
         5'd16: r = 32'h000028BE;
         5'd17: r = 32'h0000145F;
         5'd18: r = 32'h00000A30;
         5'd19: r = 32'h00000518;
         5'd20: r = 32'h0000028C;
         5'd21: r = 32'h00000146;
         5'd22: r = 32'h000000A3;
         5'd23: r = 32'h00000051;
         5'd24: r = 32'h00000029;
         5'd25: r = 32'h00000014;
         5'd26: r = 32'h0000000A;
         5'd27: r = 32'h00000005;
         5'd28: r = 32'h00000003;
         5'd29: r = 32'h00000001;
         5'd30: r = 32'h00000001;
         default: r = 32'h00000000;
      endcase
      return r;
   endfunction

   // Q28 to Q14, round half up, clamp to +-1.0
   function automatic logic [15:0] q28_to_q14(input logic signed [39:0] v);
      logic signed [39:0] t;
      logic [15:0] r;
      t = (v + 40'sd8192) >>> 14;
      if (t > 40'sd16384) r = 16'sd16384;
      else if (t < -40'sd16384) r = -16'sd16384;
      else r = t[15:0];
      return r;
   endfunction

   // Q28 product sum to Q0, round half up, saturate to 32 bits
   function automatic logic [31:0] rnd_sat32(input logic signed [67:0] v);
      logic signed [67:0] t;
      logic [31:0] r;
      t = (v + ROUND_Q28) >>> 28;
      if (t > 68'sd2147483647) r = 32'h7FFFFFFF;
      else if (t < -68'sd2147483648) r = 32'h80000000;
      else r = t[31:0];
      return r;
   endfunction

endpackage

// ----- src/planar_pose_reorigin.sv -----
// Top level of the planar pose re-origin block.
// A pose that yields a result is worked on by three passes of the one shared CORDIC unit plus 12 multiply
// steps; the engine takes the next pose from the queue only after the result register has taken this one.
// Poses that yield no result are taken every cycle while the two-entry queue has room.
// Reset (synchronous, active high) clears the origin, the message match flag, queue and result.
`timescale 1ns / 1ps
module planar_pose_reorigin #(
   parameter int CORDIC_STEPS = 16
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic signed [31:0] req_pos_x,
   input  logic signed [31:0] req_pos_y,
   input  logic signed [15:0] req_quat_x,
   input  logic signed [15:0] req_quat_y,
   input  logic signed [15:0] req_quat_z,
   input  logic signed [15:0] req_quat_w,
   input  logic               req_tracked_frame,
   input  logic               req_message_start,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic signed [31:0] rsp_rel_x,
   output logic signed [31:0] rsp_rel_y,
   output logic signed [15:0] rsp_rel_yaw,
   output logic signed [15:0] rsp_orient_z,
   output logic signed [15:0] rsp_orient_w
);
   import ppr_pkg::*;

   logic q_full, q_empty, q_push, q_pop;
   ppr_entry_type q_wdata, q_rdata;

   ppr_front u_front (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_pos_x         (req_pos_x),
      .req_pos_y         (req_pos_y),
      .req_quat_x        (req_quat_x),
      .req_quat_y        (req_quat_y),
      .req_quat_z        (req_quat_z),
      .req_quat_w        (req_quat_w),
      .req_tracked_frame (req_tracked_frame),
      .req_message_start (req_message_start),
      .q_full            (q_full),
      .q_push            (q_push),
      .q_data            (q_wdata)
   );

   ppr_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_data (q_wdata),
      .pop       (q_pop),
      .pop_data  (q_rdata),
      .full      (q_full),
      .empty     (q_empty)
   );

   ppr_back #(
      .CORDIC_STEPS (CORDIC_STEPS)
   ) u_back (
      .clock        (clock),
      .reset        (reset),
      .q_empty      (q_empty),
      .q_data       (q_rdata),
      .q_pop        (q_pop),
      .rsp_valid    (rsp_valid),
      .rsp_ready    (rsp_ready),
      .rsp_rel_x    (rsp_rel_x),
      .rsp_rel_y    (rsp_rel_y),
      .rsp_rel_yaw  (rsp_rel_yaw),
      .rsp_orient_z (rsp_orient_z),
      .rsp_orient_w (rsp_orient_w)
   );

endmodule

// ----- src/ppr_front.sv -----
// Input stage: accepts transactions, tracks the per-message match flag, forwards poses to work on.
`timescale 1ns / 1ps
module ppr_front (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  logic signed [31:0]     req_pos_x,
   input  logic signed [31:0]     req_pos_y,
   input  logic signed [15:0]     req_quat_x,
   input  logic signed [15:0]     req_quat_y,
   input  logic signed [15:0]     req_quat_z,
   input  logic signed [15:0]     req_quat_w,
   input  logic                   req_tracked_frame,
   input  logic                   req_message_start,
   input  logic                   q_full,
   output logic                   q_push,
   output ppr_pkg::ppr_entry_type q_data
);
   import ppr_pkg::*;

   logic matched_ff, matched_in;
   logic matched_cur;
   logic accept;

   assign req_ready = ~q_full;
   assign accept    = req_valid & req_ready;

   always_comb begin
      matched_cur = req_message_start ? 1'b0 : matched_ff;
      q_push      = accept & req_tracked_frame & ~matched_cur;
      matched_in  = matched_ff;
      if (accept) begin
         matched_in = matched_cur | req_tracked_frame;
      end
      q_data.pos_x  = req_pos_x;
      q_data.pos_y  = req_pos_y;
      q_data.quat_x = req_quat_x;
      q_data.quat_y = req_quat_y;
      q_data.quat_z = req_quat_z;
      q_data.quat_w = req_quat_w;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         matched_ff <= 1'b0;
      end else begin
         matched_ff <= matched_in;
      end
   end

endmodule

// ----- src/ppr_queue.sv -----
// Short queue of pose entries between the input stage and the compute engine.
`timescale 1ns / 1ps
module ppr_queue (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   push,
   input  ppr_pkg::ppr_entry_type push_data,
   input  logic                   pop,
   output ppr_pkg::ppr_entry_type pop_data,
   output logic                   full,
   output logic                   empty
);
   import ppr_pkg::*;

   localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

   ppr_entry_type slot_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0] wr_ff, wr_in, rd_ff, rd_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;

   assign full     = (cnt_ff == CNT_W'(QUEUE_DEPTH));
   assign empty    = (cnt_ff == '0);
   assign pop_data = slot_ff[rd_ff];

   always_comb begin
      wr_in  = wr_ff;
      rd_in  = rd_ff;
      cnt_in = cnt_ff;
      if (push) begin
         wr_in = (wr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ff + 1'b1;
      end
      if (pop) begin
         rd_in = (rd_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ff + 1'b1;
      end
      if (push && !pop) cnt_in = cnt_ff + 1'b1;
      else if (pop && !push) cnt_in = cnt_ff - 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ff] <= push_data;
      end
   end

endmodule

// ----- src/ppr_back.sv -----
// Compute engine: quaternion yaw, origin latch, CORDIC sine/cosine, rotation, result register.
`timescale 1ns / 1ps
module ppr_back #(
   parameter int CORDIC_STEPS = 16
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   q_empty,
   input  ppr_pkg::ppr_entry_type q_data,
   output logic                   q_pop,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output logic signed [31:0]     rsp_rel_x,
   output logic signed [31:0]     rsp_rel_y,
   output logic signed [15:0]     rsp_rel_yaw,
   output logic signed [15:0]     rsp_orient_z,
   output logic signed [15:0]     rsp_orient_w
);
   import ppr_pkg::*;

   localparam logic [4:0] LAST_STEP = 5'(CORDIC_STEPS - 1);

   bk_state_type state_ff, state_in;
   logic [4:0] iter_ff, iter_in;
   ppr_entry_type ent_ff, ent_in;
   logic signed [67:0] acc_ff, acc_in;
   logic signed [35:0] sn_ff, sn_in;
   logic signed [39:0] cx_ff, cx_in, cy_ff, cy_in;
   logic signed [33:0] cz_ff, cz_in;
   logic zero_ff, zero_in, neg_ff, neg_in;
   logic [15:0] yaw_ff, yaw_in, ryaw_ff, ryaw_in;
   logic oval_ff, oval_in;
   logic signed [31:0] ox_ff, ox_in, oy_ff, oy_in;
   logic [15:0] oyaw_ff, oyaw_in;
   logic signed [33:0] c_ff, c_in, s_ff, s_in;
   logic signed [32:0] dx_ff, dx_in, dy_ff, dy_in;
   logic [15:0] oz_ff, oz_in, ow_ff, ow_in;
   logic [31:0] rx_ff, rx_in;
   logic out_valid_ff, out_valid_in;
   logic [31:0] out_x_ff, out_x_in, out_y_ff, out_y_in;
   logic [15:0] out_yaw_ff, out_yaw_in, out_z_ff, out_z_in, out_w_ff, out_w_in;

   // shared multiplier
   logic signed [33:0] mul_a;
   logic signed [16:0] mul_b;
   logic signed [50:0] prod;
   logic signed [67:0] term, base;
   logic signed [32:0] dsel;

   // CORDIC datapath
   logic signed [39:0] xsh, ysh, x_nx, y_nx;
   logic signed [33:0] at, z_nx;

   logic signed [35:0] cn;
   logic signed [33:0] ang, ang_f;
   logic ang_neg;
   logic [31:0] zr;
   logic signed [39:0] fx, fy;

   assign prod = mul_a * mul_b;

   assign rsp_valid    = out_valid_ff;
   assign rsp_rel_x    = out_x_ff;
   assign rsp_rel_y    = out_y_ff;
   assign rsp_rel_yaw  = out_yaw_ff;
   assign rsp_orient_z = out_z_ff;
   assign rsp_orient_w = out_w_ff;

   always_comb begin
      // multiplier operands
      mul_a = '0;
      mul_b = '0;
      term  = '0;
      base  = '0;
      dsel  = (iter_ff[2] ^ iter_ff[1]) ? dy_ff : dx_ff;
      if (state_ff == BK_QMUL) begin
         case (iter_ff[1:0])
            2'd0: begin mul_a = 34'(ent_ff.quat_w); mul_b = 17'(ent_ff.quat_z); end
            2'd1: begin mul_a = 34'(ent_ff.quat_x); mul_b = 17'(ent_ff.quat_y); end
            2'd2: begin mul_a = 34'(ent_ff.quat_y); mul_b = 17'(ent_ff.quat_y); end
            default: begin mul_a = 34'(ent_ff.quat_z); mul_b = 17'(ent_ff.quat_z); end
         endcase
         term = 68'(prod);
         base = iter_ff[0] ? acc_ff : '0;
      end else begin
         mul_a = iter_ff[1] ? s_ff : c_ff;
         mul_b = iter_ff[0] ? dsel[32:16] : $signed({1'b0, dsel[15:0]});
         term  = iter_ff[0] ? (68'(prod) <<< 16) : 68'(prod);
         base  = (iter_ff[1:0] == 2'd0) ? '0 : acc_ff;
      end

      // one CORDIC iteration, vectoring for yaw, rotation for sine/cosine
      xsh = cx_ff >>> iter_ff;
      ysh = cy_ff >>> iter_ff;
      at  = $signed({2'b00, atan_lut(iter_ff)});
      if (state_ff == BK_ATAN) begin
         if (!cy_ff[39]) begin
            x_nx = cx_ff + ysh; y_nx = cy_ff - xsh; z_nx = cz_ff + at;
         end else begin
            x_nx = cx_ff - ysh; y_nx = cy_ff + xsh; z_nx = cz_ff - at;
         end
      end else begin
         if (!cz_ff[33]) begin
            x_nx = cx_ff - ysh; y_nx = cy_ff + xsh; z_nx = cz_ff - at;
         end else begin
            x_nx = cx_ff + ysh; y_nx = cy_ff - xsh; z_nx = cz_ff + at;
         end
      end
      fx = neg_ff ? -x_nx : x_nx;
      fy = neg_ff ? -y_nx : y_nx;
      zr = z_nx[31:0] + 32'h00008000;

      cn = 36'(ONE_Q28) - (36'(acc_ff) <<< 1);

      // sine/cosine start angle, folded into the right half plane
      if (state_ff == BK_S1INIT) ang = $signed({{2{oyaw_ff[15]}}, oyaw_ff, 16'h0000});
      else ang = $signed({{3{ryaw_ff[15]}}, ryaw_ff, 15'h0000});
      ang_neg = 1'b0;
      ang_f   = ang;
      if (ang > QUARTER_TURN) begin
         ang_f = ang - HALF_TURN; ang_neg = 1'b1;
      end else if (ang < -QUARTER_TURN) begin
         ang_f = ang + HALF_TURN; ang_neg = 1'b1;
      end
   end

   always_comb begin
      state_in = state_ff;
      iter_in  = iter_ff;
      ent_in   = ent_ff;
      acc_in   = acc_ff;
      sn_in    = sn_ff;
      cx_in    = cx_ff;
      cy_in    = cy_ff;
      cz_in    = cz_ff;
      zero_in  = zero_ff;
      neg_in   = neg_ff;
      yaw_in   = yaw_ff;
      ryaw_in  = ryaw_ff;
      oval_in  = oval_ff;
      ox_in    = ox_ff;
      oy_in    = oy_ff;
      oyaw_in  = oyaw_ff;
      c_in     = c_ff;
      s_in     = s_ff;
      dx_in    = dx_ff;
      dy_in    = dy_ff;
      oz_in    = oz_ff;
      ow_in    = ow_ff;
      rx_in    = rx_ff;
      q_pop    = 1'b0;
      out_valid_in = out_valid_ff & ~rsp_ready;
      out_x_in   = out_x_ff;
      out_y_in   = out_y_ff;
      out_yaw_in = out_yaw_ff;
      out_z_in   = out_z_ff;
      out_w_in   = out_w_ff;

      case (state_ff)
         BK_IDLE: begin
            if (!q_empty) begin
               q_pop    = 1'b1;
               ent_in   = q_data;
               iter_in  = '0;
               state_in = BK_QMUL;
            end
         end
         BK_QMUL: begin
            acc_in  = base + term;
            iter_in = iter_ff + 1'b1;
            if (iter_ff[1:0] == 2'd2) sn_in = 36'(acc_ff) <<< 1;
            if (iter_ff[1:0] == 2'd3) state_in = BK_AINIT;
         end
         BK_AINIT: begin
            zero_in = (cn == '0) && (sn_ff == '0);
            if (cn < 0) begin
               cx_in = -40'(cn); cy_in = -40'(sn_ff); cz_in = 34'h080000000;
            end else begin
               cx_in = 40'(cn); cy_in = 40'(sn_ff); cz_in = '0;
            end
            iter_in  = '0;
            state_in = BK_ATAN;
         end
         BK_ATAN: begin
            cx_in = x_nx; cy_in = y_nx; cz_in = z_nx;
            iter_in = iter_ff + 1'b1;
            if (iter_ff == LAST_STEP) begin
               yaw_in = zero_ff ? 16'h0000 : zr[31:16];
               if (!oval_ff) begin
                  oval_in = 1'b1;
                  ox_in   = ent_ff.pos_x;
                  oy_in   = ent_ff.pos_y;
                  oyaw_in = zero_ff ? 16'h0000 : zr[31:16];
               end
               state_in = BK_S1INIT;
            end
         end
         BK_S1INIT, BK_S2INIT: begin
            cx_in   = GAIN_INV_Q28;
            cy_in   = '0;
            cz_in   = ang_f;
            neg_in  = ang_neg;
            iter_in = '0;
            if (state_ff == BK_S1INIT) begin
               dx_in    = 33'(ent_ff.pos_x) - 33'(ox_ff);
               dy_in    = 33'(ent_ff.pos_y) - 33'(oy_ff);
               state_in = BK_SC1;
            end else begin
               state_in = BK_SC2;
            end
         end
         BK_SC1: begin
            cx_in = x_nx; cy_in = y_nx; cz_in = z_nx;
            iter_in = iter_ff + 1'b1;
            if (iter_ff == LAST_STEP) begin
               c_in     = 34'(fx);
               s_in     = 34'(fy);
               ryaw_in  = yaw_ff - oyaw_ff;
               state_in = BK_S2INIT;
            end
         end
         BK_SC2: begin
            cx_in = x_nx; cy_in = y_nx; cz_in = z_nx;
            iter_in = iter_ff + 1'b1;
            if (iter_ff == LAST_STEP) begin
               ow_in    = q28_to_q14(fx);
               oz_in    = q28_to_q14(fy);
               iter_in  = '0;
               state_in = BK_ROT;
            end
         end
         BK_ROT: begin
            // x: c*dx + s*dy, then y: c*dy - s*dx, each as low/high partial products
            acc_in  = (iter_ff[2] & iter_ff[1]) ? base - term : base + term;
            iter_in = iter_ff + 1'b1;
            if (iter_ff[2:0] == 3'd4) rx_in = rnd_sat32(acc_ff);
            if (iter_ff[2:0] == 3'd7) state_in = BK_RFIN;
         end
         BK_RFIN: begin
            if (!out_valid_ff || rsp_ready) begin
               out_valid_in = 1'b1;
               out_x_in     = rx_ff;
               out_y_in     = rnd_sat32(acc_ff);
               out_yaw_in   = ryaw_ff;
               out_z_in     = oz_ff;
               out_w_in     = ow_ff;
               state_in     = BK_IDLE;
            end
         end
         default: state_in = BK_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= BK_IDLE;
         out_valid_ff <= 1'b0;
         oval_ff      <= 1'b0;
         ox_ff        <= '0;
         oy_ff        <= '0;
         oyaw_ff      <= '0;
      end else begin
         state_ff     <= state_in;
         out_valid_ff <= out_valid_in;
         oval_ff      <= oval_in;
         ox_ff        <= ox_in;
         oy_ff        <= oy_in;
         oyaw_ff      <= oyaw_in;
      end
   end

   always_ff @(posedge clock) begin
      iter_ff    <= iter_in;
      ent_ff     <= ent_in;
      acc_ff     <= acc_in;
      sn_ff      <= sn_in;
      cx_ff      <= cx_in;
      cy_ff      <= cy_in;
      cz_ff      <= cz_in;
      zero_ff    <= zero_in;
      neg_ff     <= neg_in;
      yaw_ff     <= yaw_in;
      ryaw_ff    <= ryaw_in;
      c_ff       <= c_in;
      s_ff       <= s_in;
      dx_ff      <= dx_in;
      dy_ff      <= dy_in;
      oz_ff      <= oz_in;
      ow_ff      <= ow_in;
      rx_ff      <= rx_in;
      out_x_ff   <= out_x_in;
      out_y_ff   <= out_y_in;
      out_yaw_ff <= out_yaw_in;
      out_z_ff   <= out_z_in;
      out_w_ff   <= out_w_in;
   end

endmodule

// ----- sim/planar_pose_reorigin_tb.sv -----
// Testbench for the planar pose re-origin block: directed and randomized poses checked against a local model.
`timescale 1ns / 1ps
module planar_pose_reorigin_tb;
   import ppr_pkg::*;

   localparam int STEPS = 16;
   localparam int IDLE_LIMIT = 20000;

   typedef struct packed {
      logic signed [31:0] px;
      logic signed [31:0] py;
      logic signed [15:0] qx;
      logic signed [15:0] qy;
      logic signed [15:0] qz;
      logic signed [15:0] qw;
      logic               trk;
      logic               start;
   } pose_type;

   typedef struct packed {
      logic signed [31:0] rx;
      logic signed [31:0] ry;
      logic signed [15:0] yaw;
      logic signed [15:0] oz;
      logic signed [15:0] ow;
   } rel_pose_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   logic signed [31:0] req_pos_x = '0, req_pos_y = '0;
   logic signed [15:0] req_quat_x = '0, req_quat_y = '0, req_quat_z = '0, req_quat_w = '0;
   logic req_tracked_frame = 1'b0, req_message_start = 1'b0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   logic signed [31:0] rsp_rel_x, rsp_rel_y;
   logic signed [15:0] rsp_rel_yaw, rsp_orient_z, rsp_orient_w;

   planar_pose_reorigin #(.CORDIC_STEPS(STEPS)) u_top (.*);

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   pose_type     pose_queue[$];
   rel_pose_type expected_poses[$];
   int           errors = 0;
   bit           hold_sender = 0;
   int           hold_rsp = 0;

   // local copy of origin state
   bit               org_valid = 0;
   longint           org_x = 0, org_y = 0;
   logic [15:0]      org_yaw = 0;
   bit               matched = 0;

   function automatic longint asr(longint v, int s);
      return v >>> s;
   endfunction

   function automatic logic [31:0] atan_step(int i);
      logic [31:0] t[32] = '{32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
         32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55, 32'h0028BE53,
         32'h00145F2F, 32'h000A2F98, 32'h000517CC, 32'h00028BE6, 32'h000145F3,
         32'h0000A2FA, 32'h0000517D, 32'h000028BE, 32'h0000145F, 32'h00000A30,
         32'h00000518, 32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051,
         32'h00000029, 32'h00000014, 32'h0000000A, 32'h00000005, 32'h00000003,
         32'h00000001, 32'h00000001, 32'h00000000};
      return t[i];
   endfunction

   function automatic logic [31:0] yaw_angle(longint c, longint s);
      longint x, y, nx;
      logic [31:0] z;
      x = c;
      y = s;
      z = 0;
      if (c == 0 && s == 0) return 0;
      if (x < 0) begin
         x = -x;
         y = -y;
         z = 32'h80000000;
      end
      for (int i = 0; i < STEPS; i++) begin
         if (y >= 0) begin
            nx = x + asr(y, i);
            y = y - asr(x, i);
            z = z + atan_step(i);
         end else begin
            nx = x - asr(y, i);
            y = y + asr(x, i);
            z = z - atan_step(i);
         end
         x = nx;
      end
      return z;
   endfunction

   task automatic rotate_vec(input longint ang, output longint co, output longint si);
      longint x, y, nx, a;
      bit neg;
      x = 163008219;
      y = 0;
      a = ang;
      neg = 0;
      if (a > 64'sd1073741824) begin
         a -= 64'sd2147483648;
         neg = 1;
      end else if (a < -64'sd1073741824) begin
         a += 64'sd2147483648;
         neg = 1;
      end
      for (int i = 0; i < STEPS; i++) begin
         if (a >= 0) begin
            nx = x - asr(y, i);
            y = y + asr(x, i);
            a -= longint'(atan_step(i));
         end else begin
            nx = x + asr(y, i);
            y = y - asr(x, i);
            a += longint'(atan_step(i));
         end
         x = nx;
      end
      co = neg ? -x : x;
      si = neg ? -y : y;
   endtask

   function automatic logic [31:0] round_sat(longint a, longint b, longint c, longint d);
      logic signed [67:0] v;
      v = (68'(signed'(a)) * 68'(signed'(b)) + 68'(signed'(c)) * 68'(signed'(d))
           + 68'sd134217728) >>> 28;
      if (v > 68'sd2147483647) return 32'h7FFFFFFF;
      if (v < -68'sd2147483648) return 32'h80000000;
      return v[31:0];
   endfunction

   function automatic logic [15:0] to_q14(longint v);
      longint t;
      t = asr(v + 8192, 14);
      if (t > 16384) t = 16384;
      if (t < -16384) t = -16384;
      return t[15:0];
   endfunction

   task automatic predict_pose(input pose_type p);
      longint sn, cn, c, s, hc, hs, dx, dy;
      logic [31:0] ya;
      logic [15:0] yaw, ry;
      rel_pose_type r;
      if (p.start) matched = 0;
      if (!p.trk || matched) return;
      matched = 1;
      sn = 2 * (longint'(p.qw) * p.qz + longint'(p.qx) * p.qy);
      cn = 64'sd268435456 - 2 * (longint'(p.qy) * p.qy + longint'(p.qz) * p.qz);
      ya = yaw_angle(cn, sn) + 32'h8000;
      yaw = ya[31:16];
      if (!org_valid) begin
         org_x = p.px;
         org_y = p.py;
         org_yaw = yaw;
         org_valid = 1;
      end
      dx = longint'(p.px) - org_x;
      dy = longint'(p.py) - org_y;
      rotate_vec(longint'($signed(org_yaw)) * 65536, c, s);
      r.rx = round_sat(c, dx, s, dy);
      r.ry = round_sat(c, dy, -s, dx);
      ry = yaw - org_yaw;
      rotate_vec(longint'($signed(ry)) * 32768, hc, hs);
      r.yaw = ry;
      r.oz = to_q14(hs);
      r.ow = to_q14(hc);
      expected_poses.push_back(r);
   endtask

   task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
      errors++;
      $display("mismatch %s: got %h expected %h", what, got, want);
   endtask

   function automatic logic [15:0] rand_q();
      case ($urandom_range(0, 5))
         0: return 16'sd16384;
         1: return -16'sd16384;
         2: return 16'sd0;
         3: return 16'($urandom);
         default: return 16'(int'($urandom_range(0, 32768)) - 16384);
      endcase
   endfunction

   function automatic logic [31:0] rand_pos();
      case ($urandom_range(0, 5))
         0: return 32'h7FFFFFFF;
         1: return 32'h80000000;
         2: return 32'(int'($urandom_range(0, 2000000)) - 1000000);
         default: return $urandom;
      endcase
   endfunction

   function automatic pose_type rand_pose(bit trk, bit st);
      pose_type p;
      p.px = rand_pos();
      p.py = rand_pos();
      p.qx = rand_q();
      p.qy = rand_q();
      p.qz = rand_q();
      p.qw = rand_q();
      p.trk = trk;
      p.start = st;
      return p;
   endfunction

   // driver
   int send_gap = 0;
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && req_ready) begin
            predict_pose(pose_queue.pop_front());
            send_gap = $urandom_range(0, 3) == 0 ? $urandom_range(0, 12) : 0;
         end
         if (!(req_valid && !req_ready)) begin
            if (send_gap > 0) begin
               send_gap--;
               req_valid <= 1'b0;
            end else if (pose_queue.size() > 0 && !hold_sender) begin
               req_valid <= 1'b1;
               {req_pos_x, req_pos_y, req_quat_x, req_quat_y, req_quat_z, req_quat_w,
                req_tracked_frame, req_message_start} <= pose_queue[0];
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // monitor
   int rsp_gap = 0;
   always @(posedge clock) begin
      rel_pose_type e;
      if (!reset) begin
         if (rsp_valid && rsp_ready) begin
            if (expected_poses.size() == 0) begin
               report("unexpected result", 32'(rsp_rel_x), 32'h0);
            end else begin
               e = expected_poses.pop_front();
               if (rsp_rel_x !== e.rx) report("rel_x", rsp_rel_x, e.rx);
               if (rsp_rel_y !== e.ry) report("rel_y", rsp_rel_y, e.ry);
               if (rsp_rel_yaw !== e.yaw)
                  report("rel_yaw", 32'(rsp_rel_yaw), 32'(e.yaw));
               if (rsp_orient_z !== e.oz)
                  report("orient_z", 32'(rsp_orient_z), 32'(e.oz));
               if (rsp_orient_w !== e.ow)
                  report("orient_w", 32'(rsp_orient_w), 32'(e.ow));
            end
            rsp_gap = $urandom_range(0, 2) == 0 ? $urandom_range(0, 12) : 0;
         end
         if (hold_rsp > 0) begin
            hold_rsp--;
            rsp_ready <= 1'b0;
         end else if (rsp_gap > 0) begin
            rsp_gap--;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   // watchdog
   int idle_cycles = 0;
   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
         $display("*** FAILED ***");
         $finish;
      end
   end

   initial begin
      bit st;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      // directed: origin, extremes, degenerate quaternion, start+tracked, second tracked, untracked
      pose_queue.push_back('{32'sd100000, -32'sd50000, 0, 0, 16'sd11585, 16'sd11585, 1, 1});
      pose_queue.push_back('{32'h7FFFFFFF, 32'h7FFFFFFF, 0, 0, 0, 16'sd16384, 1, 0});
      pose_queue.push_back('{32'h80000000, 32'h80000000, 0, 0, 16'sd16384, 0, 1, 1});
      pose_queue.push_back('{32'h7FFFFFFF, 32'h80000000, 0, 0, -16'sd16384, 0, 1, 1});
      pose_queue.push_back('{0, 0, 16'sd16384, 16'sd16384, 0, 0, 1, 1});
      pose_queue.push_back('{0, 0, 0, 16'sd11585, 0, 0, 1, 1});
      pose_queue.push_back('{5, 5, 16'sd16384, 0, 0, 0, 0, 1});
      pose_queue.push_back('{7, 7, -16'sd16384, -16'sd16384, -16'sd16384, -16'sd16384, 1, 0});
      pose_queue.push_back('{32'hFFFFFFFF, 1, 16'h7FFF, 16'h8000, 16'h7FFF, 16'h8000, 1, 1});
      pose_queue.push_back('{1, 32'hFFFFFFFF, 16'h8000, 16'h7FFF, 16'h8000, 16'h7FFF, 1, 1});
      for (int i = 0; i < 6; i++) pose_queue.push_back(rand_pose(1, 1));
      wait (pose_queue.size() == 0 && expected_poses.size() == 0);
      // sender pause until drained, then receiver holds off while sender pushes
      hold_sender = 1;
      repeat (80) @(posedge clock);
      hold_sender = 0;
      hold_rsp = 400;
      for (int i = 0; i < 20; i++) pose_queue.push_back(rand_pose(1, 1));
      for (int i = 0; i < 780; i++) begin
         // random poses: start set three times in four, tracked two times in three
         st = ($urandom_range(0, 3) != 0);
         pose_queue.push_back(rand_pose($urandom_range(0, 2) != 0, st));
      end
      wait (pose_queue.size() == 0 && !req_valid);
      wait (expected_poses.size() == 0);
      repeat (200) @(posedge clock);
      if (errors == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end
endmodule
